### src/pdh_pkg.sv
// Shared constants, codes and types of the pair distance histogram unit.
package pdh_pkg;

   // Sizing of the histogram store and of the position arithmetic
   localparam int SPECIES_MAX = 4;
   localparam int BIN_MAX     = 256;
   localparam int COORD_BITS  = 23;

   // Fixed field widths
   localparam int ACT_W      = 2;
   localparam int SPC_W      = 2;
   localparam int POS_W      = 23;
   localparam int RBIN_W     = 8;
   localparam int BINF_W     = 8;
   localparam int CNT_W      = 32;
   localparam int BWID_W     = 20;
   localparam int BLIM_W     = 9;
   localparam int BOX_W      = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 80;

   // Store geometry
   localparam int CELLS  = SPECIES_MAX * SPECIES_MAX * BIN_MAX;
   localparam int ADDR_W = $clog2(CELLS);

   // Datapath widths of the bin calculation
   localparam int AX_W   = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
   localparam int SQR_W  = 2 * AX_W;
   localparam int SQ_W   = SQR_W + 2;
   localparam int RAD_W  = SQ_W + 2;
   localparam int ROOT_W = RAD_W / 2;
   localparam int NUM_W  = ((ROOT_W > BWID_W) ? ROOT_W : BWID_W) + 1;
   localparam int DEN_W  = BWID_W + 1;
   localparam int STEP_W = $clog2(NUM_W + 1);

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_BIN_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_Z     = 3'd4;

   // Register reset values
   localparam logic [BWID_W-1:0] BIN_WIDTH_RST = 20'd410;
   localparam logic [BLIM_W-1:0] BIN_LIMIT_RST = 9'd100;
   localparam logic [BOX_W-1:0]  BOX_RST       = 23'd40960;

   // Item kinds
   typedef enum logic [ACT_W-1:0] {
      ACT_PAIR   = 2'd0,
      ACT_SAMPLE = 2'd1,
      ACT_READ   = 2'd2
   } pdh_action_type;

   // Top level sequencer
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CALC,
      S_READ,
      S_UPDATE,
      S_DONE
   } pdh_state_type;

   // Bin calculation sequencer
   typedef enum logic [3:0] {
      C_IDLE,
      C_MOD,
      C_FOLD,
      C_SQR,
      C_SUM1,
      C_SUM2,
      C_ROOT,
      C_LOAD,
      C_DIV,
      C_DONE
   } pdh_calc_state_type;

endpackage

### src/pdh_ram.sv
// Generic simple dual-port RAM with registered read.
module pdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### src/pdh_bin_calc.sv
// Bit-serial distance and bin calculation: fold, square, root and divide.
module pdh_bin_calc import pdh_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2:0][COORD_BITS-1:0]  pos_a,
   input  logic [2:0][COORD_BITS-1:0]  pos_b,
   input  logic [2:0][BOX_W-1:0]       box,
   input  logic [BWID_W-1:0]           bin_width,
   output logic                        done,
   output logic [NUM_W-1:0]            bin_k
);

   pdh_calc_state_type         state_ff, state_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [2:0][AX_W-1:0]       dist_ff, dist_in;
   logic [2:0][AX_W-1:0]       shift_ff, shift_in;
   logic [2:0][BOX_W-1:0]      rem_ff, rem_in;
   logic [2:0][SQR_W-1:0]      sqr_ff, sqr_in;
   logic [RAD_W-1:0]           rad_ff, rad_in;
   logic [ROOT_W:0]            srem_ff, srem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [DEN_W-1:0]           drem_ff, drem_in;
   logic [NUM_W-1:0]           num_ff, num_in;

   logic [2:0][COORD_BITS-1:0] mag;
   logic [2:0][BOX_W:0]        mod_t;
   logic [2:0][BOX_W-1:0]      mod_next;
   logic [2:0][AX_W-1:0]       fold;
   logic [ROOT_W+2:0]          root_t;
   logic [ROOT_W+2:0]          root_trial;
   logic                       root_ge;
   logic [BWID_W-1:0]          width_eff;
   logic [DEN_W:0]             div_t;
   logic [DEN_W:0]             div_den;
   logic                       div_ge;

   assign bin_k = num_ff;

   // Per-axis displacement, remainder step and minimum-image fold
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]   = (pos_a[i] >= pos_b[i]) ? pos_a[i] - pos_b[i] : pos_b[i] - pos_a[i];
         mod_t[i] = {rem_ff[i], shift_ff[i][AX_W-1]};
         if (mod_t[i] >= {1'b0, box[i]}) begin
            mod_next[i] = BOX_W'(mod_t[i] - {1'b0, box[i]});
         end else begin
            mod_next[i] = mod_t[i][BOX_W-1:0];
         end
         if (box[i] == '0) begin
            fold[i] = dist_ff[i];
         end else if ({rem_ff[i], 1'b0} > {1'b0, box[i]}) begin
            fold[i] = AX_W'(box[i] - rem_ff[i]);
         end else begin
            fold[i] = AX_W'(rem_ff[i]);
         end
      end
   end

   // Square root step: two radicand bits per cycle
   assign root_t     = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_ge    = (root_t >= root_trial);

   // Division step: one quotient bit per cycle
   assign width_eff = (bin_width == '0) ? BWID_W'(1) : bin_width;
   assign div_t     = {drem_ff, num_ff[NUM_W-1]};
   assign div_den   = {1'b0, width_eff, 1'b0};
   assign div_ge    = (div_t >= div_den);

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff - STEP_W'(1);
      dist_in  = dist_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      sqr_in   = sqr_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      drem_in  = drem_ff;
      num_in   = num_ff;
      done     = 1'b0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  dist_in[i]  = AX_W'(mag[i]);
                  shift_in[i] = AX_W'(mag[i]);
                  rem_in[i]   = '0;
               end
               step_in  = STEP_W'(AX_W - 1);
               state_in = C_MOD;
            end
         end
         C_MOD: begin
            for (int i = 0; i < 3; i++) begin
               rem_in[i]   = mod_next[i];
               shift_in[i] = shift_ff[i] << 1;
            end
            if (step_ff == '0) begin
               state_in = C_FOLD;
            end
         end
         C_FOLD: begin
            for (int i = 0; i < 3; i++) begin
               dist_in[i]  = fold[i];
               shift_in[i] = fold[i];
               sqr_in[i]   = '0;
            end
            step_in  = STEP_W'(AX_W - 1);
            state_in = C_SQR;
         end
         C_SQR: begin
            // Square by shift and add, multiplier bits from the top
            for (int i = 0; i < 3; i++) begin
               sqr_in[i]   = (sqr_ff[i] << 1)
                           + (shift_ff[i][AX_W-1] ? SQR_W'(dist_ff[i]) : '0);
               shift_in[i] = shift_ff[i] << 1;
            end
            if (step_ff == '0) begin
               state_in = C_SUM1;
            end
         end
         C_SUM1: begin
            rad_in   = RAD_W'(SQ_W'(sqr_ff[0]) + SQ_W'(sqr_ff[1]));
            state_in = C_SUM2;
         end
         C_SUM2: begin
            // Radicand is four times the squared distance
            rad_in   = {rad_ff[SQ_W-1:0] + SQ_W'(sqr_ff[2]), 2'b00};
            srem_in  = '0;
            root_in  = '0;
            step_in  = STEP_W'(ROOT_W - 1);
            state_in = C_ROOT;
         end
         C_ROOT: begin
            if (root_ge) begin
               srem_in = (ROOT_W+1)'(root_t - root_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = root_t[ROOT_W:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            if (step_ff == '0) begin
               state_in = C_LOAD;
            end
         end
         C_LOAD: begin
            // Nearest centre: (2r + w) / 2w
            num_in   = NUM_W'(root_ff) + NUM_W'(width_eff);
            drem_in  = '0;
            step_in  = STEP_W'(NUM_W - 1);
            state_in = C_DIV;
         end
         C_DIV: begin
            if (div_ge) begin
               drem_in = DEN_W'(div_t - div_den);
            end else begin
               drem_in = div_t[DEN_W-1:0];
            end
            num_in = {num_ff[NUM_W-2:0], div_ge};
            if (step_ff == '0) begin
               state_in = C_DONE;
            end
         end
         C_DONE: begin
            done     = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      dist_ff  <= dist_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      sqr_ff   <= sqr_in;
      rad_ff   <= rad_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      drem_ff  <= drem_in;
      num_ff   <= num_in;
   end

endmodule

### src/pair_distance_histogram_unit.sv
// Top level of the pair distance histogram unit.
// Accumulates a radial distribution histogram per ordered species pair in a
// 4096 x 32-bit RAM. After reset the unit clears the RAM one entry a cycle
// and accepts no item until that pass ends; configuration writes are taken
// throughout and should be made only while the unit is idle. A pair item is
// worked one at a time through a bit-serial datapath: periodic remainder, a
// fold, shift-and-add squaring, summing of the squares, square root, a load
// and division, then a read-modify-write of the count. The next item is
// accepted while a result still waits on the response channel.
module pair_distance_histogram_unit import pdh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // species_first, species_second, first_x, first_y, first_z,
   // second_x, second_y, second_z, read_bin
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [ACT_W-1:0]      req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bin_found, counted, bin_count, samples_taken
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   pdh_state_type              state_ff, state_in;
   logic [ADDR_W-1:0]          clear_addr_ff, clear_addr_in;
   logic [BWID_W-1:0]          bin_width_ff;
   logic [BLIM_W-1:0]          bin_limit_ff;
   logic [2:0][BOX_W-1:0]      box_ff;
   logic [ACT_W-1:0]           action_ff, action_in;
   logic [SPC_W-1:0]           sf_ff, sf_in;
   logic [SPC_W-1:0]           ss_ff, ss_in;
   logic [BINF_W-1:0]          bin_ff, bin_in;
   logic                       counted_ff, counted_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [BINF_W-1:0]          rsp_bin_ff, rsp_bin_in;
   logic                       rsp_counted_ff, rsp_counted_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]           samples_ff, samples_in;

   logic [ACT_W-1:0]           req_action;
   logic [SPC_W-1:0]           req_sf;
   logic [SPC_W-1:0]           req_ss;
   logic [RBIN_W-1:0]          req_read_bin;
   logic [2:0][COORD_BITS-1:0] pos_a;
   logic [2:0][COORD_BITS-1:0] pos_b;
   logic                       accept;
   logic                       calc_start;
   logic                       calc_done;
   logic [NUM_W-1:0]           calc_k;
   logic [NUM_W-1:0]           lim;
   logic                       pair_ok;
   logic [CNT_W-1:0]           inc_count;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [CNT_W-1:0]           ram_wdata;
   logic                       ram_re;
   logic [CNT_W-1:0]           ram_rdata;

   // Store address of one count
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [SPC_W-1:0] a,
                                                   input logic [SPC_W-1:0] b,
                                                   input logic [NUM_W-1:0] bin);
      return ADDR_W'((int'(a) * SPECIES_MAX + int'(b)) * BIN_MAX) + ADDR_W'(bin);
   endfunction

   // Unpack the request transaction
   assign req_action   = req_tuser;
   assign req_sf       = req_tdata[1:0];
   assign req_ss       = req_tdata[3:2];
   assign pos_a[0]     = req_tdata[4 +: COORD_BITS];
   assign pos_a[1]     = req_tdata[27 +: COORD_BITS];
   assign pos_a[2]     = req_tdata[50 +: COORD_BITS];
   assign pos_b[0]     = req_tdata[73 +: COORD_BITS];
   assign pos_b[1]     = req_tdata[96 +: COORD_BITS];
   assign pos_b[2]     = req_tdata[119 +: COORD_BITS];
   assign req_read_bin = req_tdata[149:142];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign calc_start = accept && (req_action == ACT_PAIR);
   assign csr_ready  = 1'b1;

   // Pack the response transaction
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, samples_ff, rsp_count_ff, rsp_counted_ff, rsp_bin_ff};

   // Bin limit capped to the store, and the counting decision
   assign lim       = (bin_limit_ff > BLIM_W'(BIN_MAX)) ? NUM_W'(BIN_MAX)
                                                         : NUM_W'(bin_limit_ff);
   assign pair_ok   = (calc_k < lim) && (int'(sf_ff) < SPECIES_MAX)
                                     && (int'(ss_ff) < SPECIES_MAX);
   assign inc_count = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + CNT_W'(1);

   pdh_bin_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .start     (calc_start),
      .pos_a     (pos_a),
      .pos_b     (pos_b),
      .box       (box_ff),
      .bin_width (bin_width_ff),
      .done      (calc_done),
      .bin_k     (calc_k)
   );

   pdh_ram #(
      .WIDTH (CNT_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // Sequencer: clear, accept, compute, read-modify-write, respond
   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      action_in      = action_ff;
      sf_in          = sf_ff;
      ss_in          = ss_ff;
      bin_in         = bin_ff;
      counted_in     = counted_ff;
      count_in       = count_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_bin_in     = rsp_bin_ff;
      rsp_counted_in = rsp_counted_ff;
      rsp_count_in   = rsp_count_ff;
      samples_in     = samples_ff;
      ram_we         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = inc_count;
      ram_re         = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ram_we        = 1'b1;
            ram_waddr     = clear_addr_ff;
            ram_wdata     = '0;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               action_in  = req_action;
               sf_in      = req_sf;
               ss_in      = req_ss;
               counted_in = 1'b0;
               count_in   = '0;
               bin_in     = '0;
               addr_in    = cell_addr(req_sf, req_ss, NUM_W'(req_read_bin));
               case (req_action)
                  ACT_PAIR: begin
                     state_in = S_CALC;
                  end
                  ACT_READ: begin
                     bin_in = BINF_W'(req_read_bin);
                     if ((int'(req_read_bin) < BIN_MAX) && (int'(req_sf) < SPECIES_MAX)
                         && (int'(req_ss) < SPECIES_MAX)) begin
                        state_in = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_CALC: begin
            if (calc_done) begin
               bin_in     = (calc_k > NUM_W'(255)) ? '1 : BINF_W'(calc_k);
               counted_in = pair_ok;
               addr_in    = cell_addr(sf_ff, ss_ff, calc_k);
               state_in   = pair_ok ? S_READ : S_DONE;
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            // Bump and write back a pair count, pass a read straight through
            if (action_ff == ACT_PAIR) begin
               ram_we   = 1'b1;
               count_in = inc_count;
            end else begin
               count_in = ram_rdata;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_bin_in     = bin_ff;
               rsp_counted_in = counted_ff;
               rsp_count_in   = count_ff;
               if ((action_ff == ACT_SAMPLE) && (samples_ff != COUNT_MAX)) begin
                  samples_in = samples_ff + CNT_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         samples_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         samples_ff    <= samples_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= BIN_WIDTH_RST;
         bin_limit_ff <= BIN_LIMIT_RST;
         box_ff[0]    <= BOX_RST;
         box_ff[1]    <= BOX_RST;
         box_ff[2]    <= BOX_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BIN_WIDTH: bin_width_ff <= csr_data[BWID_W-1:0];
            REG_BIN_LIMIT: bin_limit_ff <= csr_data[BLIM_W-1:0];
            REG_BOX_X:     box_ff[0]    <= csr_data[BOX_W-1:0];
            REG_BOX_Y:     box_ff[1]    <= csr_data[BOX_W-1:0];
            REG_BOX_Z:     box_ff[2]    <= csr_data[BOX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      sf_ff          <= sf_in;
      ss_ff          <= ss_in;
      bin_ff         <= bin_in;
      counted_ff     <= counted_in;
      count_ff       <= count_in;
      addr_ff        <= addr_in;
      rsp_bin_ff     <= rsp_bin_in;
      rsp_counted_ff <= rsp_counted_in;
      rsp_count_ff   <= rsp_count_in;
   end

`ifndef SYNTHESIS
   // Outside the clearing pass the store is written only to bump a counted pair
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff != S_CLEAR)) |->
         ((state_ff == S_UPDATE) && (action_ff == ACT_PAIR) && counted_ff))
      else $error("histogram store written outside a counted pair update");

   // A counted pair always reports a non-zero count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_counted_ff) |-> (rsp_count_ff != '0))
      else $error("counted pair reported with zero count");

   // The sample counter moves only when a response is loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(samples_ff))
      else $error("sample counter changed outside response load");

   // A bin inside the limit goes on to the store, one outside does not
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CALC) && calc_done) |=> (counted_ff == (state_ff == S_READ)))
      else $error("counting decision and sequencer disagree");
`endif

endmodule

### verif/tb_pair_distance_histogram_unit.sv
// Self-checking testbench of the pair distance histogram unit: directed table, then random phases.
module tb_pair_distance_histogram_unit;
   import pdh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_MAX     = 8388607;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 240;
   localparam int PLAN_ROWS   = 32;
   localparam int TAIL_CYCLES = 120;
   localparam int PRINT_MAX   = 40;

   // Spare action code: the unit must leave its state alone
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   localparam logic [POS_W-1:0] PZ = '0;
   localparam logic [POS_W-1:0] PM = POS_W'(POS_MAX);

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [SPC_W-1:0]  sf;
      logic [SPC_W-1:0]  ss;
      logic [POS_W-1:0]  fx;
      logic [POS_W-1:0]  fy;
      logic [POS_W-1:0]  fz;
      logic [POS_W-1:0]  sx;
      logic [POS_W-1:0]  sy;
      logic [POS_W-1:0]  sz;
      logic [RBIN_W-1:0] rbin;
   } pair_req_type;

   typedef struct packed {
      logic [BINF_W-1:0] bin_found;
      logic              counted;
      logic [CNT_W-1:0]  bin_count;
      logic [CNT_W-1:0]  samples_taken;
   } pair_rsp_type;

   typedef struct {
      pair_req_type item;
      bit           typed;
      pair_rsp_type want;
   } issued_type;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      pair_req_type          item;
      bit                    typed;
      pair_rsp_type          want;
   } plan_row_type;

   localparam pair_req_type NO_ITEM = '0;
   localparam pair_rsp_type NO_RSP  = '0;

   // Directed table: reset state, self pairs, ordered pairs, spare action, bin edges,
   // wrap folds, then register extremes (zero width, wide limit, zero and unit boxes)
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, '0, '0, '{ACT_READ, 2'd0, 2'd0, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd0}},
      '{ROW_ITEM, '0, '0, '{ACT_SAMPLE, 2'd0, 2'd0, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd1, 2'd2, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b1, 32'd1, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd1, 2'd2, PM, PM, PM, PM, PM, PM, 8'd0},
        1'b1, '{8'd0, 1'b1, 32'd2, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_READ, 2'd1, 2'd2, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd2, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_READ, 2'd2, 2'd1, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_SPARE, 2'd3, 2'd3, PM, PM, PM, PM, PM, PM, 8'd255},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd3, 2'd3, PZ, PZ, PZ, PM, PM, PM, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd1, PZ, PZ, PZ, 23'd205, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd1, 23'd204, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd1, 23'd100, PZ, PZ, 23'd40860, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0,
        '{ACT_PAIR, 2'd2, 2'd3, 23'd20480, 23'd20480, 23'd20480, PZ, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_READ, 2'd3, 2'd3, PZ, PZ, PZ, PZ, PZ, PZ, 8'd255},
        1'b1, '{8'd255, 1'b0, 32'd0, 32'd1}},
      '{ROW_ITEM, '0, '0, '{ACT_SAMPLE, 2'd0, 2'd0, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd2}},
      '{ROW_REG, REG_BIN_WIDTH, 23'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BIN_LIMIT, 23'd511, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_X, 23'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_Y, 23'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_Z, 23'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd0, PM, PM, PM, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd255, 1'b0, 32'd0, 32'd2}},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd0, PZ, PZ, PZ, 23'd1, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd0, PZ, PZ, PZ, 23'd255, PZ, PZ, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_READ, 2'd0, 2'd0, PZ, PZ, PZ, PZ, PZ, PZ, 8'd255},
        1'b0, NO_RSP},
      '{ROW_REG, REG_BIN_LIMIT, 23'd0, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd0, 2'd0, PZ, PZ, PZ, PZ, PZ, PZ, 8'd0},
        1'b1, '{8'd0, 1'b0, 32'd0, 32'd2}},
      '{ROW_REG, REG_BIN_WIDTH, 23'd1048575, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BIN_LIMIT, 23'd256, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_X, 23'd1, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_Y, PM, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_REG, REG_BOX_Z, 23'd1, NO_ITEM, 1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd1, 2'd1, 23'd5, PZ, 23'd77, 23'd9000, PM, 23'd3, 8'd0},
        1'b0, NO_RSP},
      '{ROW_ITEM, '0, '0, '{ACT_PAIR, 2'd1, 2'd1, PZ, PZ, PZ, PZ, 23'd4194304, PZ, 8'd0},
        1'b0, NO_RSP}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [ACT_W-1:0]      req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // Predictor state: register mirror, histogram store and sample counter
   logic [BWID_W-1:0] cfg_width = BIN_WIDTH_RST;
   logic [BLIM_W-1:0] cfg_limit = BIN_LIMIT_RST;
   logic [BOX_W-1:0]  cfg_box_x = BOX_RST;
   logic [BOX_W-1:0]  cfg_box_y = BOX_RST;
   logic [BOX_W-1:0]  cfg_box_z = BOX_RST;
   logic [CNT_W-1:0]  tally [SPECIES_MAX][SPECIES_MAX][BIN_MAX];
   logic [CNT_W-1:0]  samples_begun = '0;

   issued_type   issued_items [$];
   pair_rsp_type awaited_results [$];

   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count   = 0;
   bit          quiet        = 1'b0;
   int unsigned pos_reach    = 40960;
   int unsigned rsp_hold     = 0;
   logic [SPC_W-1:0]  recent_sf  = '0;
   logic [SPC_W-1:0]  recent_ss  = '0;
   logic [RBIN_W-1:0] recent_bin = '0;

   pair_distance_histogram_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   initial begin
      for (int a = 0; a < SPECIES_MAX; a++)
         for (int b = 0; b < SPECIES_MAX; b++)
            for (int c = 0; c < BIN_MAX; c++)
               tally[a][b][c] = '0;
   end

   // Minimum periodic image of one axis; a zero box leaves the axis unwrapped
   function automatic longint unsigned fold_to_image(input logic [POS_W-1:0] a,
                                                     input logic [POS_W-1:0] b,
                                                     input logic [BOX_W-1:0] len);
      longint unsigned ua, ub, mag, span;
      ua = a;
      ub = b;
      span = len;
      mag = (ua >= ub) ? ua - ub : ub - ua;
      if (span == 0)
         return mag;
      mag = mag % span;
      if (2 * mag > span)
         mag = span - mag;
      return mag;
   endfunction

   // Integer square root, two bits per step
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root, probe, rest;
      root = 0;
      rest = v;
      probe = 64'd1 << 62;
      while (probe > rest)
         probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Work out the result of one accepted item and update the histogram mirror
   function automatic pair_rsp_type histogram_step(input pair_req_type it);
      pair_rsp_type    r;
      longint unsigned dx, dy, dz, sq, w, two_r, k, lim;
      r = '0;
      if (it.act == ACT_PAIR) begin
         dx = fold_to_image(it.fx, it.sx, cfg_box_x);
         dy = fold_to_image(it.fy, it.sy, cfg_box_y);
         dz = fold_to_image(it.fz, it.sz, cfg_box_z);
         sq = dx * dx + dy * dy + dz * dz;
         w = (cfg_width == 0) ? 64'd1 : 64'(cfg_width);
         two_r = floor_root(4 * sq);
         k = (two_r + w) / (2 * w);
         lim = (cfg_limit < BIN_MAX) ? 64'(cfg_limit) : 64'(BIN_MAX);
         r.bin_found = (k > 255) ? 8'd255 : 8'(k);
         if (k < lim && it.sf < SPECIES_MAX && it.ss < SPECIES_MAX) begin
            if (tally[it.sf][it.ss][k] != COUNT_MAX)
               tally[it.sf][it.ss][k] = tally[it.sf][it.ss][k] + 1;
            r.counted = 1'b1;
            r.bin_count = tally[it.sf][it.ss][k];
            recent_sf = it.sf;
            recent_ss = it.ss;
            recent_bin = 8'(k);
         end
      end else if (it.act == ACT_SAMPLE) begin
         if (samples_begun != COUNT_MAX)
            samples_begun = samples_begun + 1;
      end else if (it.act == ACT_READ) begin
         r.bin_found = it.rbin;
         if (it.sf < SPECIES_MAX && it.ss < SPECIES_MAX)
            r.bin_count = tally[it.sf][it.ss][it.rbin];
      end
      r.samples_taken = samples_begun;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (fail_count < PRINT_MAX)
         $display("mismatch at result %0d, %s: got %0d, want %0d", results_seen, what, got,
                  want);
      fail_count++;
   endtask

   // Mirror register writes, predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      issued_type   issued;
      pair_rsp_type got, want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BIN_WIDTH: cfg_width = csr_data[BWID_W-1:0];
               REG_BIN_LIMIT: cfg_limit = csr_data[BLIM_W-1:0];
               REG_BOX_X:     cfg_box_x = csr_data[BOX_W-1:0];
               REG_BOX_Y:     cfg_box_y = csr_data[BOX_W-1:0];
               REG_BOX_Z:     cfg_box_z = csr_data[BOX_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            issued = issued_items.pop_front();
            want = histogram_step(issued.item);
            awaited_results.push_back(issued.typed ? issued.want : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.bin_found     = rsp_tdata[7:0];
            got.counted       = rsp_tdata[8];
            got.bin_count     = rsp_tdata[40:9];
            got.samples_taken = rsp_tdata[72:41];
            if (awaited_results.size() == 0) begin
               report_mismatch("result with nothing outstanding", 0, 0);
            end else begin
               want = awaited_results.pop_front();
               if (got.bin_found != want.bin_found)
                  report_mismatch("bin_found", got.bin_found, want.bin_found);
               if (got.counted != want.counted)
                  report_mismatch("counted", got.counted, want.counted);
               if (got.bin_count != want.bin_count)
                  report_mismatch("bin_count", got.bin_count, want.bin_count);
               if (got.samples_taken != want.samples_taken)
                  report_mismatch("samples_taken", got.samples_taken, want.samples_taken);
            end
            results_seen++;
         end
      end
   end

   // Stall the result channel in short random bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one item and hold it until the transaction completes; valid stays high after
   task automatic send_item(input pair_req_type it, input bit typed, input pair_rsp_type want);
      int unsigned gap;
      csr_valid <= 1'b0;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      issued_items.push_back('{it, typed, want});
      req_tvalid <= 1'b1;
      req_tuser <= it.act;
      req_tdata <= {2'b00, it.rbin, it.sz, it.sy, it.sx, it.fz, it.fy, it.fx, it.ss, it.sf};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Write one register; valid is left high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Drop the request and wait for every outstanding result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (results_seen != items_sent)
         @(posedge clock);
   endtask

   // Pick a fresh set of registers for the next phase, extremes now and then
   task automatic retune();
      logic [CSR_DATA_W-1:0] box_len [3];
      logic [CSR_DATA_W-1:0] lim_val, wid_val;
      int unsigned           base, eff_lim, ax;
      base = $urandom_range(2048, 65536);
      pos_reach = base;
      for (ax = 0; ax < 3; ax++) begin
         case ($urandom_range(0, 11))
            0:       box_len[ax] = '0;
            1:       box_len[ax] = CSR_DATA_W'($urandom_range(1, 64));
            2:       box_len[ax] = CSR_DATA_W'($urandom_range(0, POS_MAX));
            3:       box_len[ax] = CSR_DATA_W'($urandom_range(2048, 65536));
            default: box_len[ax] = CSR_DATA_W'(base);
         endcase
      end
      case ($urandom_range(0, 9))
         0:       lim_val = '0;
         1:       lim_val = CSR_DATA_W'($urandom_range(257, 511));
         2:       lim_val = CSR_DATA_W'($urandom_range(0, POS_MAX));
         default: lim_val = CSR_DATA_W'($urandom_range(1, 256));
      endcase
      eff_lim = lim_val[BLIM_W-1:0];
      if (eff_lim > BIN_MAX)
         eff_lim = BIN_MAX;
      if (eff_lim == 0)
         eff_lim = 1;
      // Spread the likely distances over roughly the bins in use
      case ($urandom_range(0, 9))
         0:       wid_val = '0;
         1:       wid_val = CSR_DATA_W'($urandom_range(0, POS_MAX));
         default: wid_val = CSR_DATA_W'(base / eff_lim + $urandom_range(0, base / (2 * eff_lim)));
      endcase
      write_reg(REG_BIN_WIDTH, wid_val);
      write_reg(REG_BIN_LIMIT, lim_val);
      write_reg(REG_BOX_X, box_len[0]);
      write_reg(REG_BOX_Y, box_len[1]);
      write_reg(REG_BOX_Z, box_len[2]);
   endtask

   // Mostly pairs inside the box, with reads aimed at recently counted cells
   function automatic pair_req_type random_item();
      pair_req_type it;
      int unsigned  pick;
      it.act = ACT_PAIR;
      it.sf = SPC_W'($urandom_range(0, 3));
      it.ss = SPC_W'($urandom_range(0, 3));
      it.rbin = RBIN_W'($urandom_range(0, 255));
      it.fx = POS_W'($urandom_range(0, POS_MAX));
      it.fy = POS_W'($urandom_range(0, POS_MAX));
      it.fz = POS_W'($urandom_range(0, POS_MAX));
      it.sx = POS_W'($urandom_range(0, POS_MAX));
      it.sy = POS_W'($urandom_range(0, POS_MAX));
      it.sz = POS_W'($urandom_range(0, POS_MAX));
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         pick = $urandom_range(0, 9);
         if (pick != 0) begin
            it.fx = POS_W'($urandom_range(0, pos_reach));
            it.fy = POS_W'($urandom_range(0, pos_reach));
            it.fz = POS_W'($urandom_range(0, pos_reach));
            it.sx = POS_W'($urandom_range(0, pos_reach));
            it.sy = POS_W'($urandom_range(0, pos_reach));
            it.sz = POS_W'($urandom_range(0, pos_reach));
         end
         // Self pair at distance zero
         if (pick == 1) begin
            it.sx = it.fx;
            it.sy = it.fy;
            it.sz = it.fz;
         end
      end else if (pick < 70) begin
         it.act = ACT_SAMPLE;
      end else if (pick < 95) begin
         it.act = ACT_READ;
         if ($urandom_range(0, 1) == 1) begin
            it.sf = recent_sf;
            it.ss = recent_ss;
            it.rbin = recent_bin;
         end
      end else begin
         it.act = ACT_SPARE;
      end
      return it;
   endfunction

   initial begin
      int row, phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (row = 0; row < PLAN_ROWS; row++) begin
         if (plan[row].kind == ROW_REG) begin
            wait_drained();
            write_reg(plan[row].reg_idx, plan[row].reg_val);
         end else begin
            send_item(plan[row].item, plan[row].typed, plan[row].want);
         end
      end

      // Random phases, each under its own register settings; the last runs without idling
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         if (phase == PHASES - 1)
            quiet = 1'b1;
         retune();
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, NO_RSP);
      end

      csr_valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         report_mismatch("results still outstanding", awaited_results.size(), 0);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
src/pdh_pkg.sv
src/pdh_ram.sv
src/pdh_bin_calc.sv
src/pair_distance_histogram_unit.sv
verif/tb_pair_distance_histogram_unit.sv
